// File: rtl/ppcs_pkg.sv
`timescale 1ns / 1ps

package ppcs_pkg;

	localparam int TICK_BITS_DEFAULT = 32;
	localparam int NOW_WIDTH = 32;
	localparam int TIMEOUT_WIDTH = 16;
	localparam int FAULT_WIDTH = 7;
	localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd1000;

	// Sticky fault bit positions.
	localparam int FB_INVALID = 0;
	localparam int FB_EFUSE_ON_TO = 1;
	localparam int FB_CHARGER_ON_TO = 2;
	localparam int FB_CHARGER_OFF_TO = 3;
	localparam int FB_EFUSE_OFF_TO = 4;
	localparam int FB_PANEL0 = 5;
	localparam int FB_PANEL1 = 6;

	typedef enum logic [3:0] {
		ST_STARTUP     = 4'd0,
		ST_MPPT_OFF    = 4'd1,
		ST_EFUSE_ON    = 4'd2,
		ST_CHARGER_ON  = 4'd3,
		ST_UMBILICAL   = 4'd4,
		ST_CHARGER_OFF = 4'd5,
		ST_EFUSE_OFF   = 4'd6,
		ST_MPPT_ON     = 4'd7,
		ST_NORMAL      = 4'd8,
		ST_FAULT       = 4'd9
	} seq_state_t;

	// Sampled pins of one tick.
	typedef struct packed {
		logic umbilical_power_good;
		logic battery_power_good;
		logic charger_power_good;
		logic charger_ok_low;
		logic panel0_present;
		logic panel1_present;
	} pins_t;

	// Sequencer context apart from the entry time stamp.
	typedef struct packed {
		seq_state_t             state;
		logic                   entering;
		logic [FAULT_WIDTH-1:0] faults;
		logic                   charger_on;
		logic                   efuse_on;
		logic                   mppt0_on;
		logic                   mppt1_on;
	} ctx_t;

endpackage

// File: rtl/power_path_charge_sequencer.sv
`timescale 1ns / 1ps
// A tick passes through the input register and then the result register.
// Throughput: one tick per cycle unless out_stall holds the result; the state register loop is combinational.
// Reset: arst_n low clears the sequencer to startup with the entry flag set, all drives
// and fault bits off, both pipeline valids low, and the handshake timeout at 1000 ms.
module power_path_charge_sequencer
	import ppcs_pkg::*;
#(
	parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,

	// Configuration: handshake timeout in milliseconds.
	input  logic                     cfg_wr_en,
	input  logic [TIMEOUT_WIDTH-1:0] cfg_wr_data,

	// Tick input channel.
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [NOW_WIDTH-1:0]     now_ms,
	input  logic                     umbilical_power_good,
	input  logic                     battery_power_good,
	input  logic                     charger_power_good,
	input  logic                     charger_ok_low,
	input  logic                     panel0_present,
	input  logic                     panel1_present,

	// Result channel.
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [3:0]               sequencer_state,
	output logic [FAULT_WIDTH-1:0]   fault_bits,
	output logic                     charger_enable,
	output logic                     charger_efuse_enable,
	output logic                     mppt0_enable,
	output logic                     mppt1_enable
);

	logic [TIMEOUT_WIDTH-1:0] handshake_timeout_q;
	pins_t                    pins;
	pins_t                    pins_s1;
	logic                     valid_s1;
	logic [NOW_WIDTH-1:0]     now_s1;
	logic                     advance;
	ctx_t                     result_q;

	// The timeout register is to be written by the user only while the block is idle, so
	// it can feed the compare directly; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handshake_timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			handshake_timeout_q <= cfg_wr_data;
		end
	end

	assign pins = '{
		umbilical_power_good: umbilical_power_good,
		battery_power_good:   battery_power_good,
		charger_power_good:   charger_power_good,
		charger_ok_low:       charger_ok_low,
		panel0_present:       panel0_present,
		panel1_present:       panel1_present
	};

	// The input register takes a new tick whenever its current one moves
	// into the sequencer, so a result waiting on out_stall does not block
	// the next transfer by more than the one stage of buffering.
	ppcs_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_ms  (now_ms),
		.pins    (pins),
		.advance (advance),
		.valid_s1(valid_s1),
		.now_s1  (now_s1),
		.pins_s1 (pins_s1)
	);

	// The core holds the sequencer state and the result register. Each
	// tick is one state decode plus a wrap-around subtract and compare.
	ppcs_core #(
		.TICK_BITS(TICK_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.now_s1     (now_s1),
		.pins_s1    (pins_s1),
		.timeout    (handshake_timeout_q),
		.advance    (advance),
		.out_stall  (out_stall),
		.out_valid_q(out_valid),
		.result_q   (result_q)
	);

	assign sequencer_state = result_q.state;
	assign fault_bits = result_q.faults;
	assign charger_enable = result_q.charger_on;
	assign charger_efuse_enable = result_q.efuse_on;
	assign mppt0_enable = result_q.mppt0_on;
	assign mppt1_enable = result_q.mppt1_on;

endmodule

// File: rtl/ppcs_in_reg.sv
`timescale 1ns / 1ps

module ppcs_in_reg
	import ppcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [NOW_WIDTH-1:0] now_ms,
	input  pins_t                pins,
	input  logic                 advance,
	output logic                 valid_s1,
	output logic [NOW_WIDTH-1:0] now_s1,
	output pins_t                pins_s1
);

	logic load;

	// The stage can refill in the same cycle that its tick moves on.
	assign in_stall = valid_s1 & ~advance;
	assign load = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			now_s1 <= now_ms;
			pins_s1 <= pins;
		end
	end

endmodule

// File: rtl/ppcs_step.sv
`timescale 1ns / 1ps

module ppcs_step
	import ppcs_pkg::*;
#(
	parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
	input  ctx_t                     cur,
	input  logic [TICK_BITS-1:0]     entry_time,
	input  logic [TICK_BITS-1:0]     now,
	input  pins_t                    pins,
	input  logic [TIMEOUT_WIDTH-1:0] timeout,
	output ctx_t                     nxt,
	output logic [TICK_BITS-1:0]     nxt_entry_time
);

	logic [TICK_BITS-1:0] elapsed;
	logic                 timed_out;
	logic                 go;
	seq_state_t           go_state;

	// Wrap-around elapsed time since the current state was entered.
	assign elapsed = now - entry_time;
	assign timed_out = elapsed >= {{(TICK_BITS-TIMEOUT_WIDTH){1'b0}}, timeout};

	always_comb begin
		nxt = cur;
		go = 1'b0;
		go_state = cur.state;
		case (cur.state)
			ST_STARTUP: begin
				go = 1'b1;
				if (pins.umbilical_power_good) begin
					go_state = ST_MPPT_OFF;
				end else if (pins.battery_power_good) begin
					go_state = ST_CHARGER_OFF;
				end else begin
					go_state = ST_FAULT;
					nxt.faults[FB_INVALID] = 1'b1;
				end
			end
			ST_MPPT_OFF: begin
				if (cur.entering) begin
					nxt.entering = 1'b0;
					nxt.mppt0_on = 1'b0;
					nxt.mppt1_on = 1'b0;
				end else begin
					go = 1'b1;
					go_state = ST_EFUSE_ON;
				end
			end
			ST_EFUSE_ON: begin
				if (cur.entering) begin
					nxt.entering = 1'b0;
					nxt.efuse_on = 1'b1;
				end else if (pins.charger_power_good) begin
					go = 1'b1;
					go_state = ST_CHARGER_ON;
				end else if (timed_out) begin
					go = 1'b1;
					go_state = ST_FAULT;
					nxt.faults[FB_EFUSE_ON_TO] = 1'b1;
				end
			end
			ST_CHARGER_ON: begin
				if (cur.entering) begin
					nxt.entering = 1'b0;
					nxt.charger_on = 1'b1;
				end else if (!pins.charger_ok_low) begin
					go = 1'b1;
					go_state = ST_UMBILICAL;
				end else if (timed_out) begin
					go = 1'b1;
					go_state = ST_FAULT;
					nxt.faults[FB_CHARGER_ON_TO] = 1'b1;
				end
			end
			ST_UMBILICAL: begin
				if (cur.entering) begin
					nxt.entering = 1'b0;
				end else if (!pins.umbilical_power_good) begin
					go = 1'b1;
					go_state = ST_CHARGER_OFF;
				end
			end
			ST_CHARGER_OFF: begin
				if (cur.entering) begin
					nxt.entering = 1'b0;
					nxt.charger_on = 1'b0;
				end else if (pins.charger_ok_low) begin
					go = 1'b1;
					go_state = ST_EFUSE_OFF;
				end else if (timed_out) begin
					go = 1'b1;
					go_state = ST_FAULT;
					nxt.faults[FB_CHARGER_OFF_TO] = 1'b1;
				end
			end
			ST_EFUSE_OFF: begin
				if (cur.entering) begin
					nxt.entering = 1'b0;
					nxt.efuse_on = 1'b0;
				end else if (!pins.charger_power_good) begin
					go = 1'b1;
					go_state = ST_MPPT_ON;
				end else if (timed_out) begin
					go = 1'b1;
					go_state = ST_FAULT;
					nxt.faults[FB_EFUSE_OFF_TO] = 1'b1;
				end
			end
			ST_MPPT_ON: begin
				if (cur.entering) begin
					// Both channels are driven on; a missing panel is only flagged.
					nxt.entering = 1'b0;
					nxt.mppt0_on = 1'b1;
					nxt.mppt1_on = 1'b1;
					if (!pins.panel0_present) begin
						nxt.faults[FB_PANEL0] = 1'b1;
					end
					if (!pins.panel1_present) begin
						nxt.faults[FB_PANEL1] = 1'b1;
					end
				end else begin
					go = 1'b1;
					go_state = ST_NORMAL;
				end
			end
			ST_NORMAL: begin
				if (cur.entering) begin
					nxt.entering = 1'b0;
				end else if (pins.umbilical_power_good) begin
					go = 1'b1;
					go_state = ST_MPPT_OFF;
				end
			end
			ST_FAULT: begin
				if (cur.entering) begin
					nxt.entering = 1'b0;
					nxt.charger_on = 1'b0;
					nxt.efuse_on = 1'b0;
					nxt.mppt0_on = 1'b0;
					nxt.mppt1_on = 1'b0;
				end
			end
			default: begin
				go = 1'b1;
				go_state = ST_FAULT;
				nxt.faults[FB_INVALID] = 1'b1;
			end
		endcase

		nxt_entry_time = entry_time;
		if (go) begin
			nxt.state = go_state;
			nxt.entering = 1'b1;
			nxt_entry_time = now;
		end
	end

endmodule

// File: rtl/ppcs_core.sv
`timescale 1ns / 1ps

module ppcs_core
	import ppcs_pkg::*;
#(
	parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s1,
	input  logic [NOW_WIDTH-1:0]     now_s1,
	input  pins_t                    pins_s1,
	input  logic [TIMEOUT_WIDTH-1:0] timeout,
	output logic                     advance,
	input  logic                     out_stall,
	output logic                     out_valid_q,
	output ctx_t                     result_q
);

	ctx_t                 ctx_q;
	ctx_t                 ctx_nxt;
	logic [TICK_BITS-1:0] entry_time_q;
	logic [TICK_BITS-1:0] entry_time_nxt;
	logic [TICK_BITS-1:0] now_tick;

	// Tick value taken modulo 2^TICK_BITS.
	generate
		if (TICK_BITS >= NOW_WIDTH) begin : g_now_ext
			assign now_tick = {{(TICK_BITS-NOW_WIDTH){1'b0}}, now_s1};
		end else begin : g_now_trunc
			assign now_tick = now_s1[TICK_BITS-1:0];
		end
	endgenerate

	assign advance = valid_s1 & (~out_valid_q | ~out_stall);

	ppcs_step #(
		.TICK_BITS(TICK_BITS)
	) u_step (
		.cur           (ctx_q),
		.entry_time    (entry_time_q),
		.now           (now_tick),
		.pins          (pins_s1),
		.timeout       (timeout),
		.nxt           (ctx_nxt),
		.nxt_entry_time(entry_time_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '{state: ST_STARTUP, entering: 1'b1, default: '0};
			entry_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				ctx_q <= ctx_nxt;
				entry_time_q <= entry_time_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= ctx_nxt;
		end
	end

endmodule

// File: verif/power_path_charge_sequencer_test.sv
`timescale 1ns / 1ps

module power_path_charge_sequencer_test;
	import ppcs_pkg::*;

	// One task tick as it crosses the input channel.
	typedef struct packed {
		logic [NOW_WIDTH-1:0] now;
		pins_t                pins;
	} tick_t;

	// One result transfer: state, sticky faults and the four drive levels.
	typedef struct packed {
		logic [3:0]             state;
		logic [FAULT_WIDTH-1:0] faults;
		logic                   charger;
		logic                   efuse;
		logic                   mppt0;
		logic                   mppt1;
	} report_t;

	// Tracks the sequencer from the accepted ticks and holds the reports that the block owes.
	class seq_tracker;
		seq_state_t               state = ST_STARTUP;
		bit                       entering = 1'b1;
		logic [NOW_WIDTH-1:0]     entered_at = '0;
		logic [FAULT_WIDTH-1:0]   faults = '0;
		bit                       charger_on, efuse_on, mppt0_on, mppt1_on;
		logic [TIMEOUT_WIDTH-1:0] hs_limit = TIMEOUT_RESET;
		int                       dwell;
		bit                       hopped;
		int                       mismatches;
		report_t                  owed_reports[$];

		function void enter_state(seq_state_t next, logic [NOW_WIDTH-1:0] now);
			state = next;
			entering = 1'b1;
			entered_at = now;
			dwell = 0;
			hopped = 1'b1;
		endfunction

		function void trip(int bit_pos, logic [NOW_WIDTH-1:0] now);
			faults[bit_pos] = 1'b1;
			enter_state(ST_FAULT, now);
		endfunction

		// Wrap-around elapsed time against the handshake limit.
		function bit expired(logic [NOW_WIDTH-1:0] now);
			logic [NOW_WIDTH-1:0] elapsed;
			elapsed = now - entered_at;
			return elapsed >= {{(NOW_WIDTH-TIMEOUT_WIDTH){1'b0}}, hs_limit};
		endfunction

		function void accept_tick(tick_t t);
			report_t r;
			bit      fresh;
			fresh = entering;
			hopped = 1'b0;
			case (state)
				ST_STARTUP: begin
					if (t.pins.umbilical_power_good)
						enter_state(ST_MPPT_OFF, t.now);
					else if (t.pins.battery_power_good)
						enter_state(ST_CHARGER_OFF, t.now);
					else
						trip(FB_INVALID, t.now);
				end
				ST_MPPT_OFF: begin
					if (fresh) begin
						entering = 1'b0;
						mppt0_on = 1'b0;
						mppt1_on = 1'b0;
					end else begin
						enter_state(ST_EFUSE_ON, t.now);
					end
				end
				ST_EFUSE_ON: begin
					if (fresh) begin
						entering = 1'b0;
						efuse_on = 1'b1;
					end else if (t.pins.charger_power_good) begin
						enter_state(ST_CHARGER_ON, t.now);
					end else if (expired(t.now)) begin
						trip(FB_EFUSE_ON_TO, t.now);
					end
				end
				ST_CHARGER_ON: begin
					if (fresh) begin
						entering = 1'b0;
						charger_on = 1'b1;
					end else if (!t.pins.charger_ok_low) begin
						enter_state(ST_UMBILICAL, t.now);
					end else if (expired(t.now)) begin
						trip(FB_CHARGER_ON_TO, t.now);
					end
				end
				ST_UMBILICAL: begin
					if (fresh)
						entering = 1'b0;
					else if (!t.pins.umbilical_power_good)
						enter_state(ST_CHARGER_OFF, t.now);
				end
				ST_CHARGER_OFF: begin
					if (fresh) begin
						entering = 1'b0;
						charger_on = 1'b0;
					end else if (t.pins.charger_ok_low) begin
						enter_state(ST_EFUSE_OFF, t.now);
					end else if (expired(t.now)) begin
						trip(FB_CHARGER_OFF_TO, t.now);
					end
				end
				ST_EFUSE_OFF: begin
					if (fresh) begin
						entering = 1'b0;
						efuse_on = 1'b0;
					end else if (!t.pins.charger_power_good) begin
						enter_state(ST_MPPT_ON, t.now);
					end else if (expired(t.now)) begin
						trip(FB_EFUSE_OFF_TO, t.now);
					end
				end
				ST_MPPT_ON: begin
					if (fresh) begin
						entering = 1'b0;
						mppt0_on = 1'b1;
						mppt1_on = 1'b1;
						if (!t.pins.panel0_present)
							faults[FB_PANEL0] = 1'b1;
						if (!t.pins.panel1_present)
							faults[FB_PANEL1] = 1'b1;
					end else begin
						enter_state(ST_NORMAL, t.now);
					end
				end
				ST_NORMAL: begin
					if (fresh)
						entering = 1'b0;
					else if (t.pins.umbilical_power_good)
						enter_state(ST_MPPT_OFF, t.now);
				end
				ST_FAULT: begin
					if (fresh) begin
						entering = 1'b0;
						charger_on = 1'b0;
						efuse_on = 1'b0;
						mppt0_on = 1'b0;
						mppt1_on = 1'b0;
					end
				end
				default: trip(FB_INVALID, t.now);
			endcase
			if (!hopped)
				dwell++;
			r.state = state;
			r.faults = faults;
			r.charger = charger_on;
			r.efuse = efuse_on;
			r.mppt0 = mppt0_on;
			r.mppt1 = mppt1_on;
			owed_reports.push_back(r);
		endfunction

		function void flag(string what, report_t want, report_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s: want st=%0d flt=%b drv=%b%b%b%b got st=%0d flt=%b drv=%b%b%b%b",
					$time, what, want.state, want.faults, want.charger, want.efuse,
					want.mppt0, want.mppt1, got.state, got.faults, got.charger, got.efuse,
					got.mppt0, got.mppt1);
		endfunction

		function void compare_report(report_t got);
			report_t want;
			if (owed_reports.size() == 0) begin
				flag("result with nothing outstanding", '0, got);
				return;
			end
			want = owed_reports.pop_front();
			if (got.state !== want.state || got.faults !== want.faults ||
					got.charger !== want.charger || got.efuse !== want.efuse ||
					got.mppt0 !== want.mppt0 || got.mppt1 !== want.mppt1)
				flag("result mismatch", want, got);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [TIMEOUT_WIDTH-1:0] cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [NOW_WIDTH-1:0]     now_ms = '0;
	logic                     umbilical_power_good = 1'b0;
	logic                     battery_power_good = 1'b0;
	logic                     charger_power_good = 1'b0;
	logic                     charger_ok_low = 1'b0;
	logic                     panel0_present = 1'b0;
	logic                     panel1_present = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [3:0]               sequencer_state;
	logic [FAULT_WIDTH-1:0]   fault_bits;
	logic                     charger_enable;
	logic                     charger_efuse_enable;
	logic                     mppt0_enable;
	logic                     mppt1_enable;

	// While calm is set, neither side inserts idle or stall cycles.
	bit         calm = 1'b0;
	// Some runs classify the very first tick with no supply at all, which latches the
	// invalid-state fault for the rest of the run.
	bit         bad_start = 1'b0;
	seq_tracker trk = new();

	power_path_charge_sequencer dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_wr_en            (cfg_wr_en),
		.cfg_wr_data          (cfg_wr_data),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.now_ms               (now_ms),
		.umbilical_power_good (umbilical_power_good),
		.battery_power_good   (battery_power_good),
		.charger_power_good   (charger_power_good),
		.charger_ok_low       (charger_ok_low),
		.panel0_present       (panel0_present),
		.panel1_present       (panel1_present),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.sequencer_state      (sequencer_state),
		.fault_bits           (fault_bits),
		.charger_enable       (charger_enable),
		.charger_efuse_enable (charger_efuse_enable),
		.mppt0_enable         (mppt0_enable),
		.mppt1_enable         (mppt1_enable)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls at random, except during the calm stretch.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 37);
	end

	// Handshake signals only change at the rising edge, so at the falling edge they
	// show exactly what the next rising edge will see. A result seen here with valid
	// high and stall low is the one transferred at that next edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			trk.compare_report({sequencer_state, fault_bits, charger_enable,
				charger_efuse_enable, mppt0_enable, mppt1_enable});
	end

	// Builds the next tick from the tracked state, so that most ticks walk the sequence
	// forward without tripping a handshake timeout. After startup, entry ticks carry
	// random pins and times (all ones or zero in strict mode); the block tests only the
	// panel pins on them. In strict mode each handshake is missed once at the last
	// millisecond before its timeout, then met; a waiting state named by doom_at is held past it.
	function automatic tick_t make_tick(bit strict, seq_state_t doom_at);
		tick_t       t;
		bit          met;
		int          limit;
		logic [31:0] gap;
		limit = int'(trk.hs_limit);
		t.now = $urandom();
		if ($urandom_range(3) == 0)
			t.now = 32'hFFFF_FFFF - $urandom_range(0, 40);
		t.pins = pins_t'(6'($urandom_range(63)));
		if (strict && trk.entering && trk.state != ST_STARTUP)
			t.now = $urandom_range(1) ? '1 : '0;
		if (trk.state == ST_STARTUP) begin
			if (bad_start) begin
				t.pins.umbilical_power_good = 1'b0;
				t.pins.battery_power_good = 1'b0;
			end else if (!t.pins.umbilical_power_good && !t.pins.battery_power_good) begin
				t.pins.battery_power_good = 1'b1;
			end
		end else if (!trk.entering) begin
			case (trk.state)
				ST_UMBILICAL: t.pins.umbilical_power_good =
					strict ? (trk.dwell < 2) : ($urandom_range(99) >= 30);
				ST_NORMAL: t.pins.umbilical_power_good =
					strict ? (trk.dwell >= 2) : ($urandom_range(99) < 30);
				ST_EFUSE_ON, ST_CHARGER_ON, ST_CHARGER_OFF, ST_EFUSE_OFF: begin
					met = strict ? (trk.dwell >= 2) : ($urandom_range(99) < 45);
					// With a zero limit any missed handshake faults, so outside doom_at it is always met.
					if (limit == 0 && trk.state != doom_at)
						met = 1'b1;
					if (trk.state == doom_at)
						met = 1'b0;
					case (trk.state)
						ST_EFUSE_ON:    t.pins.charger_power_good = met;
						ST_CHARGER_ON:  t.pins.charger_ok_low = !met;
						ST_CHARGER_OFF: t.pins.charger_ok_low = met;
						default:        t.pins.charger_power_good = !met;
					endcase
					if (!met) begin
						if (trk.state == doom_at)
							gap = ($urandom_range(3) == 0) ? (32'h8000_0000 | $urandom())
								: (limit + $urandom_range(0, 2));
						else if (strict || $urandom_range(3) == 0)
							gap = limit - 1;
						else
							gap = $urandom_range(0, limit - 1);
						t.now = trk.entered_at + gap;
					end
				end
				default: ;
			endcase
		end
		return t;
	endfunction

	// Presents one tick, holds it until the transfer and tells the tracker about it.
	// It returns in the time step of the transfer with in_valid still high.
	task automatic send_tick(bit strict, seq_state_t doom_at);
		tick_t t;
		bit    fired;
		if (!calm) begin
			while ($urandom_range(99) < 37) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		t = make_tick(strict, doom_at);
		in_valid <= 1'b1;
		now_ms <= t.now;
		umbilical_power_good <= t.pins.umbilical_power_good;
		battery_power_good <= t.pins.battery_power_good;
		charger_power_good <= t.pins.charger_power_good;
		charger_ok_low <= t.pins.charger_ok_low;
		panel0_present <= t.pins.panel0_present;
		panel1_present <= t.pins.panel1_present;
		do begin
			@(negedge clk);
			fired = !in_stall;
			@(posedge clk);
		end while (!fired);
		trk.accept_tick(t);
	endtask

	// Stops sending and waits until every owed report has come back, then lets the
	// two-stage pipeline run empty.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (trk.owed_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_handshake_limit(logic [TIMEOUT_WIDTH-1:0] ms);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ms;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		trk.hs_limit = ms;
	endtask

	initial begin
		logic [TIMEOUT_WIDTH-1:0] phase_limit[5];
		seq_state_t               doom_at;
		int                       spin;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		bad_start = ($urandom_range(9) == 0);

		// Directed walk around the whole loop at the reset limit: every state, every
		// entry action, each handshake missed one millisecond short of its timeout and
		// then met, and times at both ends of the counter so the waits wrap.
		repeat (24) send_tick(1'b1, ST_FAULT);

		// Random phases, each under its own handshake limit, including both extremes.
		// The sender drains the block between phases, and one phase runs with no idle
		// or stall cycles at all.
		phase_limit[0] = TIMEOUT_RESET;
		phase_limit[1] = 16'hFFFF;
		phase_limit[2] = 16'd0;
		phase_limit[3] = 16'd1;
		phase_limit[4] = 16'($urandom_range(2, 50));
		for (int p = 0; p < 5; p++) begin
			if (p == 0)
				settle();
			else
				set_handshake_limit(phase_limit[p]);
			calm <= (p == 3);
			repeat (100) send_tick(1'b0, ST_FAULT);
		end
		calm <= 1'b0;

		// Drive into one handshake timeout, chosen at random, sometimes with a zero
		// limit, then keep sending random ticks to show that the fault state latches.
		set_handshake_limit($urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 30)));
		case ($urandom_range(3))
			0:       doom_at = ST_EFUSE_ON;
			1:       doom_at = ST_CHARGER_ON;
			2:       doom_at = ST_CHARGER_OFF;
			default: doom_at = ST_EFUSE_OFF;
		endcase
		spin = 0;
		while (trk.state != ST_FAULT && spin < 300) begin
			send_tick(1'b0, doom_at);
			spin++;
		end
		repeat (25) send_tick(1'b0, ST_FAULT);

		settle();
		if (trk.mismatches == 0 && trk.owed_reports.size() == 0)
			$display("power_path_charge_sequencer_test: clean");
		else
			$display("power_path_charge_sequencer_test: errors");
		$finish;
	end

	// A hang anywhere in the handshakes ends the run here.
	initial begin
		#400000;
		$display("power_path_charge_sequencer_test: errors");
		$finish;
	end

endmodule
